// ===== rtl/smac_pkg.sv =====
package smac_pkg;

   localparam int ShadowDepth = 65536;
   localparam int GranBits = $clog2(ShadowDepth);
   localparam int MaxLen = 4096;
   localparam int AddrBits = 48;
   localparam int LenBits = 13;
   localparam int CsrAddrBits = 5;

   localparam logic [1:0] CMD_CHECK = 2'd0;
   localparam logic [1:0] CMD_POISON = 2'd1;
   localparam logic [1:0] CMD_UNPOISON = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] CAUSE_NONE = 2'd0;
   localparam logic [1:0] CAUSE_POISON = 2'd1;
   localparam logic [1:0] CAUSE_REGION = 2'd2;

   localparam logic [CsrAddrBits-1:0] REG_ENABLE = 5'h00;
   localparam logic [CsrAddrBits-1:0] REG_BASE = 5'h08;
   localparam logic [CsrAddrBits-1:0] REG_LIMIT = 5'h10;
   localparam logic [CsrAddrBits-1:0] REG_SHADOW = 5'h18;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_TAIL,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic enable;
      logic [AddrBits-1:0] base;
      logic [AddrBits-1:0] limit;
      logic [AddrBits-1:0] shadow;
   } cfg_type;

   // Memory request from the sequencer to the shadow store.
   typedef struct packed {
      logic rd;
      logic wr;
      logic [GranBits-1:0] idx;
      logic [7:0] wdata;
   } mem_req_type;

endpackage

// ===== rtl/smac_store.sv =====
module smac_store
   import smac_pkg::*;
(
   input  logic clock,
   input  mem_req_type req,
   output logic [7:0] rdata
);

   logic [7:0] mem [ShadowDepth];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.idx] <= req.wdata;
      end
      if (req.rd) begin
         rdata_ff <= mem[req.idx];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/smac_csr.sv =====
module smac_csr
   import smac_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [AddrBits-1:0] pwdata,
   output logic [AddrBits-1:0] prdata,
   output cfg_type cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (paddr)
            REG_ENABLE: cfg_ff.enable <= pwdata[0];
            REG_BASE: cfg_ff.base <= pwdata;
            REG_LIMIT: cfg_ff.limit <= pwdata;
            REG_SHADOW: cfg_ff.shadow <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         REG_ENABLE: prdata = {{(AddrBits-1){1'b0}}, cfg_ff.enable};
         REG_BASE: prdata = cfg_ff.base;
         REG_LIMIT: prdata = cfg_ff.limit;
         REG_SHADOW: prdata = cfg_ff.shadow;
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/smac_seq.sv =====
module smac_seq
   import smac_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  logic [1:0] cmd,
   input  logic [AddrBits-1:0] addr,
   input  logic [LenBits-1:0] length,
   input  logic [7:0] poison_value,
   input  logic is_write,
   output logic out_valid,
   input  logic out_ready,
   output logic [3:0] out_data,
   output mem_req_type mreq,
   input  logic [7:0] mrdata
);

   // Range ends may pass the top of the address space, so granule numbers
   // carry one bit more than a plain address offset would need.
   localparam int OffW = AddrBits - 2;

   state_type state_ff, state_in;
   logic [OffW-1:0] g_ff, g_in;        // current granule
   logic [OffW-1:0] ge_ff, ge_in;      // end granule (exclusive for fill, last for check)
   logic [2:0] last_off_ff, last_off_in;
   logic [7:0] val_ff, val_in;
   logic [1:0] cmd_ff, cmd_in;
   logic rd_pend_ff, rd_pend_in;
   logic [3:0] res_ff, res_in;
   logic wr_ff, wr_in;
   logic [GranBits-1:0] clr_ff, clr_in;

   // Decode of the arriving item, registered in the idle state.
   logic [LenBits-1:0] len_sat;
   logic [AddrBits:0] end_sum, last_sum, off_e;
   logic [AddrBits-1:0] off_a;
   logic in_win, in_region;

   always_comb begin
      len_sat = (length > LenBits'(MaxLen)) ? LenBits'(MaxLen) : length;
      end_sum = {1'b0, addr} + (AddrBits+1)'(len_sat);
      last_sum = end_sum - (AddrBits+1)'(1);
      in_win = addr >= cfg.base;
      in_region = addr >= cfg.shadow && addr < cfg.limit;
      off_a = addr - cfg.base;
      off_e = ((cmd == CMD_CHECK) ? last_sum : end_sum) - {1'b0, cfg.base};
   end

   logic g_ok;
   assign g_ok = (g_ff >> GranBits) == '0;

   always_comb begin
      state_in = state_ff;
      g_in = g_ff;
      ge_in = ge_ff;
      last_off_in = last_off_ff;
      val_in = val_ff;
      cmd_in = cmd_ff;
      rd_pend_in = 1'b0;
      res_in = res_ff;
      wr_in = wr_ff;
      clr_in = clr_ff;
      mreq = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mreq.wr = 1'b1;
            mreq.idx = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               g_in = {1'b0, off_a[AddrBits-1:3]};
               ge_in = off_e[AddrBits:3];
               last_off_in = last_sum[2:0];
               cmd_in = cmd;
               wr_in = (cmd == CMD_CHECK) ? is_write : 1'b0;
               res_in = {((cmd == CMD_CHECK) ? is_write : 1'b0), CAUSE_NONE, 1'b0};
               val_in = (cmd == CMD_POISON) ? poison_value : 8'd0;
               state_in = ST_RESULT;
               if (cfg.enable && len_sat != '0) begin
                  case (cmd)
                     CMD_CHECK: begin
                        if (in_region) res_in = {is_write, CAUSE_REGION, 1'b1};
                        else if (in_win && addr <= cfg.limit) state_in = ST_WALK;
                     end
                     CMD_POISON, CMD_UNPOISON: if (in_win) state_in = ST_WALK;
                     default: ;
                  endcase
               end
            end
         end
         ST_WALK: begin
            if (cmd_ff == CMD_CHECK) begin
               if (rd_pend_ff && mrdata != 8'd0) begin
                  // the read in flight was granule g_ff - 1
                  if ((g_ff - 1'b1) != ge_ff ||
                      $signed({5'd0, last_off_ff}) >= $signed(mrdata))
                     res_in = {wr_ff, CAUSE_POISON, 1'b1};
                  state_in = ST_RESULT;
               end else if (rd_pend_ff && (g_ff - 1'b1) == ge_ff) begin
                  state_in = ST_RESULT;
               end else if (!g_ok) begin
                  // everything beyond the store reads as zero
                  state_in = ST_RESULT;
               end else begin
                  mreq.rd = 1'b1;
                  mreq.idx = g_ff[GranBits-1:0];
                  rd_pend_in = 1'b1;
                  g_in = g_ff + 1'b1;
               end
            end else begin
               if (g_ff < ge_ff && g_ok) begin
                  mreq.wr = 1'b1;
                  mreq.idx = g_ff[GranBits-1:0];
                  mreq.wdata = val_ff;
                  g_in = g_ff + 1'b1;
               end else begin
                  state_in = (cmd_ff == CMD_UNPOISON && last_off_ff != 3'd7)
                     ? ST_TAIL : ST_RESULT;
               end
            end
         end
         ST_TAIL: begin
            // unpoison: partial last granule gets length mod 8
            if ((ge_ff >> GranBits) == '0) begin
               mreq.wr = 1'b1;
               mreq.idx = ge_ff[GranBits-1:0];
               mreq.wdata = {5'd0, last_off_ff + 3'd1};
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // length mod 8 equals (last offset within the length)+1 mod 8, taken from len_sat;
   // recompute the tail value at accept.
   logic [2:0] tail_in;
   assign tail_in = len_sat[2:0] - 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rd_pend_ff <= rd_pend_in;
      end
      g_ff <= g_in;
      ge_ff <= ge_in;
      last_off_ff <= (state_ff == ST_IDLE && in_valid && cmd != CMD_CHECK)
         ? tail_in : last_off_in;
      val_ff <= val_in;
      cmd_ff <= cmd_in;
      res_ff <= res_in;
      wr_ff <= wr_in;
   end

   assign out_data = res_ff;

   assert property (@(posedge clock) disable iff (reset)
      !(mreq.rd && mreq.wr)) else $error("store read and write together");
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !in_ready) else $error("result and accept overlap");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed");

endmodule

// ===== rtl/shadow_memory_access_checker_core.sv =====
// Channel   | Direction | Payload
// req       | in        | tdata: cmd[1:0] addr[49:2] length[62:50] poison_value[70:63]
//           |           |        is_write[71]
// rsp       | out       | tdata: invalid[0] cause[2:1] access_write[3]
// csr       | in        | APB registers enable, window_base, window_limit, shadow_start
//
// After reset a clearing pass writes zero to all 65536 shadow entries, one per
// cycle; no item is accepted in that time. A check reads its granules in turn
// from the single-port shadow memory; poison writes each granule of the range,
// and unpoison also writes a partial last granule. A result waits in its
// register until taken; the next item is accepted in the cycle after.
module shadow_memory_access_checker_core
   import smac_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [71:0] req_tdata,   // cmd, addr, length, poison_value, is_write
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,    // invalid, cause, access_write, zero fill
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg;
   mem_req_type mreq;
   logic [7:0] mrdata;
   logic [3:0] res;
   logic [AddrBits-1:0] rdata;

   // Registers are 48 bits wide, so the data bus is 64 bits.
   smac_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata[AddrBits-1:0]),
      .prdata(rdata), .cfg(cfg)
   );
   assign csr_prdata = {16'd0, rdata};
   assign csr_pready = 1'b1;

   smac_store u_store (.clock(clock), .req(mreq), .rdata(mrdata));

   smac_seq u_seq (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .cmd(req_tdata[1:0]), .addr(req_tdata[49:2]), .length(req_tdata[62:50]),
      .poison_value(req_tdata[70:63]), .is_write(req_tdata[71]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res),
      .mreq(mreq), .mrdata(mrdata)
   );

   assign rsp_tdata = {4'd0, res};

endmodule
